// ===== hw/rtl/periodic_timer_deadline_scheduler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Periodic timer deadline scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_DEADLINE_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_DEADLINE_SCHEDULER_UNIT_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define PTDS_ASSERT_NOW(name, trig, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |-> (expr)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PTDS_ASSERT_NEXT(name, trig, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/ptds_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer deadline scheduler package
// Field widths, codes, slot entry layout and control bundles.
// ----------------------------------------------------------------------------
package ptds_pkg;

   localparam int PERIOD_W   = 24;
   localparam int OWNER_W    = 10;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic ACTION_ADD    = 1'b0;
   localparam logic ACTION_EXPIRE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] remaining;
      logic [OWNER_W-1:0]  owner;
   } slot_entry_type;

   typedef struct packed {
      logic rd_en;     // fetch the slot at the read index
      logic wr_en;     // write the slot at the write index
      logic wr_load;   // write a new timer instead of the updated slot
   } table_ctrl_type;

   typedef struct packed {
      logic                fires;
      logic [OWNER_W-1:0]  owner;
      logic [PERIOD_W-1:0] new_rem;
   } slot_view_type;

endpackage

// ===== hw/rtl/ptds_table.sv =====
// ----------------------------------------------------------------------------
// Periodic timer slot table
// Slot memory with registered read and the per-slot expiry update.
// ----------------------------------------------------------------------------
module ptds_table import ptds_pkg::*; #(
   parameter int SLOTS = 16,
   parameter int IW    = 4
) (
   input  logic                clock,
   input  table_ctrl_type      ctrl,
   input  logic [IW-1:0]       rd_idx,
   input  logic [IW-1:0]       wr_idx,
   input  logic [PERIOD_W-1:0] load_period,
   input  logic [OWNER_W-1:0]  load_owner,
   input  logic [PERIOD_W-1:0] elapsed,
   output slot_view_type       view
);

   slot_entry_type slot_ram_ff [SLOTS];
   slot_entry_type rd_q_ff;
   slot_entry_type wr_entry;
   logic [PERIOD_W-1:0] sub_rem;

   // Saturating subtract, reload on reaching zero.
   always_comb begin
      sub_rem = (rd_q_ff.remaining > elapsed) ? (rd_q_ff.remaining - elapsed) : '0;
      view.fires   = (sub_rem == '0);
      view.owner   = rd_q_ff.owner;
      view.new_rem = view.fires ? rd_q_ff.period : sub_rem;
   end

   always_comb begin
      if (ctrl.wr_load) begin
         wr_entry = '{period: load_period, remaining: load_period, owner: load_owner};
      end else begin
         wr_entry = '{period: rd_q_ff.period, remaining: view.new_rem,
                      owner: rd_q_ff.owner};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         slot_ram_ff[wr_idx] <= wr_entry;
      end
      if (ctrl.rd_en) begin
         rd_q_ff <= slot_ram_ff[rd_idx];
      end
   end

endmodule

// ===== hw/rtl/periodic_timer_deadline_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Periodic timer deadline scheduler unit
// Table of periodic timers with add and expiry items over a stream interface.
// ----------------------------------------------------------------------------
// An add item (req_tuser = 0) stores a timer in the next free slot and returns
// one item with the new shortest interval; a full table or a zero period is
// rejected with a status. An expiry item (req_tuser = 1) subtracts the current
// shortest interval from every stored timer, reloads those that reach zero and
// returns one item per fired timer in slot order; the final item carries
// rsp_tlast and the new shortest interval. Expiry on an empty table returns one
// item with status empty. An add or an empty expiry is handled in the idle state;
// an expiry sweeps the slot memory, which reads one slot per cycle, pausing while
// a fired slot must push the pending item to a busy result side, and writes
// each slot back from the read register. A result that waits in the result
// register holds off the next item; the next item can be accepted in the same
// cycle that the waiting result is taken.
// ----------------------------------------------------------------------------
`include "periodic_timer_deadline_scheduler_unit_defines.svh"

module periodic_timer_deadline_scheduler_unit import ptds_pkg::*; #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request item
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // period[23:0], owner[33:24], zero pad
   input  logic                  req_tuser,   // action
   // result item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // fired_owner[9:0], next_interval[33:10], pad
   output logic [2:0]            rsp_tuser,   // fired[0], status[2:1]
   output logic                  rsp_tlast
);

   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

   // Request fields
   logic [PERIOD_W-1:0] req_period;
   logic [OWNER_W-1:0]  req_owner;
   assign req_period = req_tdata[PERIOD_W-1:0];
   assign req_owner  = req_tdata[PERIOD_W+OWNER_W-1:PERIOD_W];

   // Control and scan state
   state_type           state_ff, state_in;
   logic [CW-1:0]       entry_count_ff, entry_count_in;
   logic [PERIOD_W-1:0] cur_min_ff, cur_min_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       proc_idx_ff, proc_idx_in;
   logic                scan_pv_ff, scan_pv_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [OWNER_W-1:0]  pend_owner_ff, pend_owner_in;
   logic [PERIOD_W-1:0] minv_ff, minv_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fired_ff, rsp_fired_in;
   logic [OWNER_W-1:0]  rsp_owner_ff, rsp_owner_in;
   logic [PERIOD_W-1:0] rsp_next_ff, rsp_next_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   table_ctrl_type      tbl_ctrl;
   slot_view_type       slot_view;
   logic [IW-1:0]       tbl_wr_idx;

   logic out_free, req_fire, in_scan, stall, proc_go, scan_done;
   logic table_full, add_ok;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign in_scan    = (state_ff == ST_SCAN);
   assign table_full = (entry_count_ff >= SLOTS_C);
   assign add_ok     = req_fire && (req_tuser == ACTION_ADD) && !table_full
                       && (req_period != '0);

   // Hold the scan when a fired slot must push the pending item to a busy output.
   assign stall     = scan_pv_ff && slot_view.fires && pend_valid_ff && !out_free;
   assign proc_go   = in_scan && scan_pv_ff && !stall;
   assign scan_done = in_scan && !scan_pv_ff && (rd_idx_ff == entry_count_ff);

   // Slot memory control: adds write the next free slot, the scan reads ahead
   // one slot and writes back the slot whose data sits in the read register.
   always_comb begin
      tbl_ctrl.rd_en   = in_scan && !stall && (rd_idx_ff < entry_count_ff);
      tbl_ctrl.wr_en   = add_ok || proc_go;
      tbl_ctrl.wr_load = add_ok;
      tbl_wr_idx       = add_ok ? entry_count_ff[IW-1:0] : proc_idx_ff[IW-1:0];
   end

   ptds_table #(
      .SLOTS (TIMER_SLOTS),
      .IW    (IW)
   ) u_table (
      .clock       (clock),
      .ctrl        (tbl_ctrl),
      .rd_idx      (rd_idx_ff[IW-1:0]),
      .wr_idx      (tbl_wr_idx),
      .load_period (req_period),
      .load_owner  (req_owner),
      .elapsed     (cur_min_ff),
      .view        (slot_view)
   );

   // Next state of the sequencer and the scan registers
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      cur_min_in     = cur_min_ff;
      rd_idx_in      = rd_idx_ff;
      proc_idx_in    = proc_idx_ff;
      scan_pv_in     = scan_pv_ff;
      pend_valid_in  = pend_valid_ff;
      pend_owner_in  = pend_owner_ff;
      minv_in        = minv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (add_ok) begin
               entry_count_in = entry_count_ff + 1'b1;
               if (entry_count_ff == '0 || req_period < cur_min_ff) begin
                  cur_min_in = req_period;
               end
            end else if (req_fire && req_tuser == ACTION_EXPIRE
                         && entry_count_ff != '0) begin
               // start the sweep over all stored slots
               state_in      = ST_SCAN;
               rd_idx_in     = '0;
               scan_pv_in    = 1'b0;
               pend_valid_in = 1'b0;
               minv_in       = '1;
            end
         end
         ST_SCAN: begin
            if (proc_go) begin
               if (slot_view.new_rem < minv_ff) begin
                  minv_in = slot_view.new_rem;
               end
               if (slot_view.fires) begin
                  pend_valid_in = 1'b1;
                  pend_owner_in = slot_view.owner;
               end
            end
            if (!stall) begin
               // advance the read pipeline by one slot
               scan_pv_in = tbl_ctrl.rd_en;
               if (tbl_ctrl.rd_en) begin
                  proc_idx_in = rd_idx_ff;
                  rd_idx_in   = rd_idx_ff + 1'b1;
               end
            end
            if (scan_done && out_free) begin
               cur_min_in = minv_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_fired_in  = rsp_fired_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      priority if (req_fire && !(req_tuser == ACTION_EXPIRE && entry_count_ff != '0)) begin
         // single-item answers: add, rejected add, expiry on empty table
         rsp_valid_in = 1'b1;
         rsp_fired_in = 1'b0;
         rsp_owner_in = '0;
         rsp_last_in  = 1'b1;
         if (req_tuser == ACTION_EXPIRE) begin
            rsp_status_in = STATUS_EMPTY;
            rsp_next_in   = '0;
         end else if (table_full) begin
            rsp_status_in = STATUS_FULL;
            rsp_next_in   = cur_min_ff;
         end else if (req_period == '0) begin
            rsp_status_in = STATUS_ZERO;
            rsp_next_in   = cur_min_ff;
         end else begin
            rsp_status_in = STATUS_OK;
            rsp_next_in   = (entry_count_ff == '0 || req_period < cur_min_ff) ?
                            req_period : cur_min_ff;
         end
      end else if (proc_go && slot_view.fires && pend_valid_ff) begin
         // a later slot fired, so the pending one is not the last
         rsp_valid_in  = 1'b1;
         rsp_fired_in  = 1'b1;
         rsp_owner_in  = pend_owner_ff;
         rsp_next_in   = '0;
         rsp_status_in = STATUS_OK;
         rsp_last_in   = 1'b0;
      end else if (scan_done && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_fired_in  = pend_valid_ff;
         rsp_owner_in  = pend_valid_ff ? pend_owner_ff : '0;
         rsp_next_in   = minv_ff;
         rsp_status_in = STATUS_OK;
         rsp_last_in   = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         cur_min_ff     <= '0;
         scan_pv_ff     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rd_idx_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         cur_min_ff     <= cur_min_in;
         scan_pv_ff     <= scan_pv_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_idx_ff      <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff   <= proc_idx_in;
      pend_owner_ff <= pend_owner_in;
      minv_ff       <= minv_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Result ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - OWNER_W - PERIOD_W){1'b0}}, rsp_next_ff, rsp_owner_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_fired_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Assertions
   `PTDS_ASSERT_NOW(a_count_bound, 1'b1, entry_count_ff <= SLOTS_C, "entry count above slots")
   `PTDS_ASSERT_NOW(a_proc_in_range, in_scan && scan_pv_ff,
                    proc_idx_ff < entry_count_ff, "scan slot beyond entry count")
   `PTDS_ASSERT_NOW(a_min_nonzero, state_ff == ST_IDLE && entry_count_ff != '0,
                    cur_min_ff != '0, "zero shortest interval with stored timers")
   `PTDS_ASSERT_NEXT(a_add_counts, add_ok,
                     entry_count_ff == $past(entry_count_ff) + 1'b1, "accepted add did not count")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Periodic timer deadline scheduler testbench
// Runs directed and random add and expiry items against a timer table
// predictor and compares every result item, field by field, in order.
// ----------------------------------------------------------------------------
module tb import ptds_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMER_SLOTS   = 16;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int TRAFFIC_ITEMS = 256;
   localparam int CALM_ITEMS    = 40;

   typedef struct packed {
      logic                fired;
      logic [OWNER_W-1:0]  owner;
      logic [PERIOD_W-1:0] next_interval;
      logic [STATUS_W-1:0] status;
      logic                last;
   } timer_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // period[23:0], owner[33:24], zero pad
   logic                  req_tuser = ACTION_ADD;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // fired_owner[9:0], next_interval[33:10], pad
   logic [2:0]            rsp_tuser;   // fired[0], status[2:1]
   logic                  rsp_tlast;

   // timer table as the predictor sees it
   logic [PERIOD_W-1:0] slot_period [TIMER_SLOTS];
   logic [PERIOD_W-1:0] slot_remaining [TIMER_SLOTS];
   logic [OWNER_W-1:0]  slot_owner [TIMER_SLOTS];
   int unsigned         timers_stored = 0;
   logic [PERIOD_W-1:0] shortest_interval = '0;

   timer_result_type pending_results[$];
   int            error_count = 0;
   int            slots_filled = 0;   // stimulus-side count of stored timers
   bit            sender_gaps_on = 1'b1;
   bit            receiver_stalls_on = 1'b1;
   bit            long_hold_req = 1'b0;

   periodic_timer_deadline_scheduler_unit #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Update the timer table for one accepted item and queue its results.
   function automatic void predict_timer_item(logic action, logic [PERIOD_W-1:0] period,
                                              logic [OWNER_W-1:0] owner);
      timer_result_type    res;
      timer_result_type    held;
      bit                  have_held;
      logic [PERIOD_W-1:0] elapsed;
      logic [PERIOD_W-1:0] lowest;
      logic [PERIOD_W-1:0] rem;
      res = '0;
      res.last = 1'b1;
      have_held = 1'b0;
      held = '0;
      if (action == ACTION_ADD) begin
         if (timers_stored >= TIMER_SLOTS) begin
            res.status = STATUS_FULL;
         end else if (period == '0) begin
            res.status = STATUS_ZERO;
         end else begin
            slot_period[timers_stored]    = period;
            slot_remaining[timers_stored] = period;
            slot_owner[timers_stored]     = owner;
            if (timers_stored == 0 || period < shortest_interval)
               shortest_interval = period;
            timers_stored++;
            res.status = STATUS_OK;
         end
         res.next_interval = shortest_interval;
         pending_results.push_back(res);
      end else if (timers_stored == 0) begin
         res.status = STATUS_EMPTY;
         pending_results.push_back(res);
      end else begin
         elapsed = shortest_interval;
         lowest  = '1;
         for (int i = 0; i < timers_stored; i++) begin
            rem = (slot_remaining[i] > elapsed) ? slot_remaining[i] - elapsed : '0;
            if (rem == '0) begin
               // reload and report; hold the newest fire so it can carry tlast
               rem = slot_period[i];
               if (have_held)
                  pending_results.push_back(held);
               held = '0;
               held.fired = 1'b1;
               held.owner = slot_owner[i];
               held.status = STATUS_OK;
               have_held = 1'b1;
            end
            slot_remaining[i] = rem;
            if (rem < lowest)
               lowest = rem;
         end
         shortest_interval = lowest;
         if (have_held) begin
            held.next_interval = lowest;
            held.last = 1'b1;
            pending_results.push_back(held);
         end else begin
            res.status = STATUS_OK;
            res.next_interval = lowest;
            pending_results.push_back(res);
         end
      end
   endfunction

   function automatic void compare_field(string field_name, int unsigned want,
                                         int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, field_name, want, got);
         error_count++;
      end
   endfunction

   // Predict on every accepted item and check every accepted result at the same
   // edge, prediction first, so ordering between processes does not matter.
   always @(posedge clock) begin : result_monitor
      timer_result_type got;
      timer_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_timer_item(req_tuser, req_tdata[PERIOD_W-1:0],
                               req_tdata[PERIOD_W+OWNER_W-1:PERIOD_W]);
         if (rsp_tvalid && rsp_tready) begin
            got.fired         = rsp_tuser[0];
            got.status        = rsp_tuser[2:1];
            got.owner         = rsp_tdata[OWNER_W-1:0];
            got.next_interval = rsp_tdata[OWNER_W+PERIOD_W-1:OWNER_W];
            got.last          = rsp_tlast;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual 0x%0h",
                        $time, got);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("fired", want.fired, got.fired);
               compare_field("fired_owner", want.owner, got.owner);
               compare_field("next_interval", want.next_interval, got.next_interval);
               compare_field("status", want.status, got.status);
               compare_field("last", want.last, got.last);
            end
         end
      end
   end

   // Result side: random stall bursts, stretches of steady acceptance, and a
   // long hold-off on request.
   initial begin : result_receiver
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else if (receiver_stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Offer one item, after an optional idle burst, and return at the edge
   // that accepts it. Valid stays high into the next item when no gap follows.
   task automatic send_item(logic action, logic [PERIOD_W-1:0] period,
                            logic [OWNER_W-1:0] owner);
      if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-PERIOD_W-OWNER_W){1'b0}}, owner, period};
      req_tuser  <= action;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly short periods so that timers coincide and fire together.
   function automatic logic [PERIOD_W-1:0] pick_period();
      if ($urandom_range(0, 9) < 7)
         return PERIOD_W'($urandom_range(1, 12));
      return PERIOD_W'($urandom_range(1, (1 << PERIOD_W) - 1));
   endfunction

   task automatic send_expiry();
      send_item(ACTION_EXPIRE, PERIOD_W'($urandom()), OWNER_W'($urandom()));
   endtask

   task automatic send_add(logic [PERIOD_W-1:0] period, logic [OWNER_W-1:0] owner);
      send_item(ACTION_ADD, period, owner);
      if (period != '0 && slots_filled < TIMER_SLOTS)
         slots_filled++;
   endtask

   // Empty table, zero period, both period extremes and coinciding timers.
   task automatic test_directed_cases();
      send_expiry();
      send_item(ACTION_EXPIRE, '1, '1);
      send_add('0, '1);
      send_add('1, '0);
      send_expiry();
      send_add(PERIOD_W'(1), '1);
      send_add('0, OWNER_W'(10'h155));
      send_add(PERIOD_W'(4), OWNER_W'(10'h2aa));
      send_add(PERIOD_W'(4), OWNER_W'(10'h155));
      send_add(PERIOD_W'(2), OWNER_W'(1));
      repeat (4) send_expiry();
   endtask

   // Fill the remaining slots with expiries mixed in.
   task automatic test_random_fill();
      while (slots_filled < TIMER_SLOTS) begin
         if ($urandom_range(0, 9) < 4)
            send_expiry();
         else if ($urandom_range(0, 19) == 0)
            send_add('0, OWNER_W'($urandom()));
         else
            send_add(pick_period(), OWNER_W'($urandom()));
      end
   endtask

   // Every add to a full table is refused, zero period included.
   task automatic test_full_table();
      send_add('1, '1);
      send_add(PERIOD_W'(1), '0);
      send_add('0, '0);
      repeat (3) send_add(PERIOD_W'($urandom()), OWNER_W'($urandom()));
   endtask

   // Hold off results for a long stretch while expiries keep coming.
   task automatic test_result_backpressure();
      long_hold_req = 1'b1;
      repeat (24) send_expiry();
   endtask

   // Mostly expiries over the full table; the tail runs without idling.
   task automatic test_random_traffic();
      for (int n = 0; n < TRAFFIC_ITEMS; n++) begin
         if (n == TRAFFIC_ITEMS - CALM_ITEMS) begin
            sender_gaps_on = 1'b0;
            receiver_stalls_on = 1'b0;
         end
         if ($urandom_range(0, 19) < 17)
            send_expiry();
         else
            send_add(PERIOD_W'($urandom()), OWNER_W'($urandom()));
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin : test_sequence
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_fill();
      test_full_table();
      test_result_backpressure();
      test_random_traffic();
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("periodic_timer_deadline_scheduler_unit test passed");
      else
         $display("periodic_timer_deadline_scheduler_unit test failed");
      $finish;
   end

   initial begin : run_limit
      #5_000_000;
      $display("periodic_timer_deadline_scheduler_unit test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ptds_pkg.sv
hw/rtl/ptds_table.sv
hw/rtl/periodic_timer_deadline_scheduler_unit.sv
dv/tb.sv
